// ----- rtl/sma_crossover_signal_defines.svh -----
// Assertion macros shared by the crossover signal checker.
`ifndef SMA_CROSSOVER_SIGNAL_DEFINES_SVH
`define SMA_CROSSOVER_SIGNAL_DEFINES_SVH

// same-cycle implication
`define SMAX_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SMAX_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/smax_pkg.sv -----
// Package: shared types and constants for the moving average crossover block.
`timescale 1ns / 1ps
package smax_pkg;

    localparam int MAX_PERIOD_DEFAULT = 64;
    localparam int PERIOD_W           = 7;
    localparam int PRICE_W            = 32;
    localparam int PROFIT_W           = 33;
    localparam int PADDR_W            = 3;
    localparam int PDATA_W            = 32;

    localparam logic [PERIOD_W-1:0] SHORT_PERIOD_RESET = 7'd5;
    localparam logic [PERIOD_W-1:0] LONG_PERIOD_RESET  = 7'd20;

    // register index, taken from paddr[2]
    typedef enum logic {
        REG_SHORT_PERIOD = 1'b0,
        REG_LONG_PERIOD  = 1'b1
    } reg_index_t;

    typedef enum logic [1:0] {
        SIG_NONE = 2'd0,
        SIG_BUY  = 2'd1,
        SIG_SELL = 2'd2
    } signal_t;

    typedef struct packed {
        logic [PERIOD_W-1:0] short_period;
        logic [PERIOD_W-1:0] long_period;
    } periods_t;

endpackage

// ----- rtl/smax_cfg.sv -----
// APB register file holding the two window periods.
`timescale 1ns / 1ps
module smax_cfg
    import smax_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    output periods_t           periods
);

    periods_t   periods_reg;
    periods_t   periods_next;
    reg_index_t index;
    logic       wr_en;

    assign index = reg_index_t'(paddr[2]);
    assign wr_en = psel && penable && pwrite;

    always_comb
    begin
        periods_next = periods_reg;
        if (wr_en)
        begin
            unique case (index)
                REG_SHORT_PERIOD: periods_next.short_period = pwdata[PERIOD_W-1:0];
                REG_LONG_PERIOD:  periods_next.long_period  = pwdata[PERIOD_W-1:0];
                default:          periods_next = periods_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            periods_reg.short_period <= SHORT_PERIOD_RESET;
            periods_reg.long_period  <= LONG_PERIOD_RESET;
        end
        else
        begin
            periods_reg <= periods_next;
        end
    end

    always_comb
    begin
        unique case (index)
            REG_SHORT_PERIOD: prdata = PDATA_W'(periods_reg.short_period);
            REG_LONG_PERIOD:  prdata = PDATA_W'(periods_reg.long_period);
            default:          prdata = '0;
        endcase
    end

    assign pready  = 1'b1;
    assign periods = periods_reg;

endmodule

// ----- rtl/smax_ring.sv -----
// Ring of running price totals: one write port, two registered read ports.
`timescale 1ns / 1ps
module smax_ring #(
    parameter int DEPTH  = 64,
    parameter int DATA_W = 38
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [DATA_W-1:0]        wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
    input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
    output logic [DATA_W-1:0]        rd_data_a,
    output logic [DATA_W-1:0]        rd_data_b
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_a_reg;
    logic [DATA_W-1:0] rd_b_reg;

    // reads see the contents before a write at the same edge
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_a_reg <= mem[rd_addr_a];
            rd_b_reg <= mem[rd_addr_b];
        end
    end

    assign rd_data_a = rd_a_reg;
    assign rd_data_b = rd_b_reg;

endmodule

// ----- rtl/sma_crossover_signal.sv -----
// Top level: simple moving average crossover buy/sell signal generator.
//
// Price channel: close_price and date_tag, one beat per sample, valid/ready.
// Result channel: signal, trade_price, profit, date_echo, position_held,
// exactly one beat per price beat, in order, valid/ready.
// Configuration: APB, short_period at 0x0, long_period at 0x4; write only
// while the block is idle. A period of zero acts as 1, above MAX_PERIOD as
// MAX_PERIOD.
// Throughput: one sample per cycle while the receiver keeps up. Window sums
// come from a ring of running totals (newest total minus the total just
// outside the window), so each sample costs one ring write and two ring
// reads on the same cycle.
// Pipeline: ring read, window sums, cross-multiply compare and trade state.
// A stalled receiver backs up stage by stage; price_ready falls only once
// every stage is full.
// Reset: periods return to 5 and 20, the sample count, totals and position
// are cleared; the ring itself needs no clearing.
`timescale 1ns / 1ps
module sma_crossover_signal
    import smax_pkg::*;
#(
    parameter int MAX_PERIOD = MAX_PERIOD_DEFAULT
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [PADDR_W-1:0]         paddr,
    input  logic [PDATA_W-1:0]         pwdata,
    output logic [PDATA_W-1:0]         prdata,
    output logic                       pready,
    input  logic                       price_valid,
    output logic                       price_ready,
    input  logic [PRICE_W-1:0]         close_price,
    input  logic [PRICE_W-1:0]         date_tag,
    output logic                       result_valid,
    input  logic                       result_ready,
    output logic [1:0]                 signal,
    output logic [PRICE_W-1:0]         trade_price,
    output logic signed [PROFIT_W-1:0] profit,
    output logic [PRICE_W-1:0]         date_echo,
    output logic                       position_held
);

    localparam int PTR_W   = $clog2(MAX_PERIOD);
    localparam int CNT_W   = $clog2(MAX_PERIOD + 1);
    localparam int ADR_W   = CNT_W + 1;
    localparam int CLAMP_W = (CNT_W > PERIOD_W) ? CNT_W : PERIOD_W;
    localparam int SUM_W   = PRICE_W + PTR_W;
    localparam int PROD_W  = SUM_W + CNT_W;

    periods_t periods;

    smax_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .periods (periods)
    );

    // effective periods
    logic [CLAMP_W-1:0] sp_wide;
    logic [CLAMP_W-1:0] lp_wide;
    logic [CNT_W-1:0]   sp_eff;
    logic [CNT_W-1:0]   lp_eff;

    assign sp_wide = CLAMP_W'(periods.short_period);
    assign lp_wide = CLAMP_W'(periods.long_period);

    always_comb
    begin
        if (sp_wide == '0)
            sp_eff = CNT_W'(1);
        else if (sp_wide > CLAMP_W'(MAX_PERIOD))
            sp_eff = CNT_W'(MAX_PERIOD);
        else
            sp_eff = sp_wide[CNT_W-1:0];

        if (lp_wide == '0)
            lp_eff = CNT_W'(1);
        else if (lp_wide > CLAMP_W'(MAX_PERIOD))
            lp_eff = CNT_W'(MAX_PERIOD);
        else
            lp_eff = lp_wide[CNT_W-1:0];
    end

    // handshake chain
    logic s1_valid_reg;
    logic s2_valid_reg;
    logic out_valid_reg;
    logic out_free;
    logic s2_ready;
    logic s1_ready;
    logic accept;
    logic s1_move;
    logic s2_move;

    assign out_free    = !out_valid_reg || result_ready;
    assign s2_ready    = !s2_valid_reg || out_free;
    assign s1_ready    = !s1_valid_reg || s2_ready;
    assign price_ready = s1_ready;
    assign accept      = price_valid && s1_ready;
    assign s1_move     = s1_valid_reg && s2_ready;
    assign s2_move     = s2_valid_reg && out_free;

    // sample bookkeeping
    logic [PTR_W-1:0] wp_reg;
    logic [PTR_W-1:0] wp_next;
    logic             wrapped_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [SUM_W-1:0] total_reg;
    logic [SUM_W-1:0] total_next;
    logic             wp_last;

    assign wp_last    = (wp_reg == PTR_W'(MAX_PERIOD - 1));
    assign wp_next    = wp_last ? '0 : wp_reg + PTR_W'(1);
    assign count_next = (count_reg == CNT_W'(MAX_PERIOD)) ? count_reg
                                                          : count_reg + CNT_W'(1);
    assign total_next = total_reg + SUM_W'(close_price);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg      <= '0;
            wrapped_reg <= 1'b0;
            count_reg   <= '0;
            total_reg   <= '0;
        end
        else if (accept)
        begin
            wp_reg      <= wp_next;
            wrapped_reg <= wrapped_reg || wp_last;
            count_reg   <= count_next;
            total_reg   <= total_next;
        end
    end

    // ring addresses of the total just outside each window
    logic [ADR_W-1:0] wp_wide;
    logic [ADR_W-1:0] s_addr_wide;
    logic [ADR_W-1:0] l_addr_wide;
    logic [PTR_W-1:0] s_addr;
    logic [PTR_W-1:0] l_addr;
    logic             s_written;
    logic             l_written;
    logic             full;

    assign wp_wide = ADR_W'(wp_reg);

    always_comb
    begin
        if (wp_wide >= ADR_W'(sp_eff))
            s_addr_wide = wp_wide - ADR_W'(sp_eff);
        else
            s_addr_wide = wp_wide + (ADR_W'(MAX_PERIOD) - ADR_W'(sp_eff));

        if (wp_wide >= ADR_W'(lp_eff))
            l_addr_wide = wp_wide - ADR_W'(lp_eff);
        else
            l_addr_wide = wp_wide + (ADR_W'(MAX_PERIOD) - ADR_W'(lp_eff));
    end

    assign s_addr    = s_addr_wide[PTR_W-1:0];
    assign l_addr    = l_addr_wide[PTR_W-1:0];
    // entries fill in order from zero, so unwritten means total zero
    assign s_written = wrapped_reg || (s_addr < wp_reg);
    assign l_written = wrapped_reg || (l_addr < wp_reg);
    assign full      = (count_next >= sp_eff) && (count_next >= lp_eff);

    logic [SUM_W-1:0] rd_short;
    logic [SUM_W-1:0] rd_long;

    smax_ring #(
        .DEPTH  (MAX_PERIOD),
        .DATA_W (SUM_W)
    ) u_ring (
        .clk       (clk),
        .wr_en     (accept),
        .wr_addr   (wp_reg),
        .wr_data   (total_next),
        .rd_en     (accept),
        .rd_addr_a (s_addr),
        .rd_addr_b (l_addr),
        .rd_data_a (rd_short),
        .rd_data_b (rd_long)
    );

    // stage 1: ring read
    logic [SUM_W-1:0]   s1_total_reg;
    logic               s1_s_written_reg;
    logic               s1_l_written_reg;
    logic               s1_full_reg;
    logic [CNT_W-1:0]   s1_sp_reg;
    logic [CNT_W-1:0]   s1_lp_reg;
    logic [PRICE_W-1:0] s1_price_reg;
    logic [PRICE_W-1:0] s1_date_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (s1_ready)
            s1_valid_reg <= price_valid;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_total_reg     <= total_next;
            s1_s_written_reg <= s_written;
            s1_l_written_reg <= l_written;
            s1_full_reg      <= full;
            s1_sp_reg        <= sp_eff;
            s1_lp_reg        <= lp_eff;
            s1_price_reg     <= close_price;
            s1_date_reg      <= date_tag;
        end
    end

    // stage 2: window sums
    logic [SUM_W-1:0]   short_sum;
    logic [SUM_W-1:0]   long_sum;
    logic [SUM_W-1:0]   s2_short_reg;
    logic [SUM_W-1:0]   s2_long_reg;
    logic               s2_full_reg;
    logic [CNT_W-1:0]   s2_sp_reg;
    logic [CNT_W-1:0]   s2_lp_reg;
    logic [PRICE_W-1:0] s2_price_reg;
    logic [PRICE_W-1:0] s2_date_reg;

    assign short_sum = s1_s_written_reg ? s1_total_reg - rd_short : s1_total_reg;
    assign long_sum  = s1_l_written_reg ? s1_total_reg - rd_long  : s1_total_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_valid_reg <= 1'b0;
        else if (s2_ready)
            s2_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (s1_move)
        begin
            s2_short_reg <= short_sum;
            s2_long_reg  <= long_sum;
            s2_full_reg  <= s1_full_reg;
            s2_sp_reg    <= s1_sp_reg;
            s2_lp_reg    <= s1_lp_reg;
            s2_price_reg <= s1_price_reg;
            s2_date_reg  <= s1_date_reg;
        end
    end

    // stage 3: compare short_sum*lp against long_sum*sp, trade state
    logic [PROD_W-1:0]   lhs;
    logic [PROD_W-1:0]   rhs;
    logic                live;
    logic                buy;
    logic                sell;
    logic                holding_reg;
    logic                holding_next;
    logic [PRICE_W-1:0]  entry_reg;
    logic [PRICE_W-1:0]  entry_next;
    signal_t             sig_next;
    logic [PROFIT_W-1:0] profit_next;

    assign lhs  = PROD_W'(s2_short_reg) * PROD_W'(s2_lp_reg);
    assign rhs  = PROD_W'(s2_long_reg) * PROD_W'(s2_sp_reg);
    assign live = s2_full_reg && (s2_short_reg != '0) && (s2_long_reg != '0);
    assign buy  = live && !holding_reg && (lhs > rhs);
    assign sell = live && holding_reg && (lhs < rhs);

    always_comb
    begin
        sig_next     = SIG_NONE;
        profit_next  = '0;
        holding_next = holding_reg;
        entry_next   = entry_reg;
        if (buy)
        begin
            sig_next     = SIG_BUY;
            holding_next = 1'b1;
            entry_next   = s2_price_reg;
        end
        else if (sell)
        begin
            sig_next     = SIG_SELL;
            holding_next = 1'b0;
            profit_next  = {1'b0, s2_price_reg} - {1'b0, entry_reg};
        end
    end

    signal_t             sig_reg;
    logic [PRICE_W-1:0]  price_out_reg;
    logic [PROFIT_W-1:0] profit_reg;
    logic [PRICE_W-1:0]  date_out_reg;
    logic                held_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            holding_reg   <= 1'b0;
            entry_reg     <= '0;
        end
        else
        begin
            if (out_free)
                out_valid_reg <= s2_valid_reg;
            if (s2_move)
            begin
                holding_reg <= holding_next;
                entry_reg   <= entry_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_move)
        begin
            sig_reg       <= sig_next;
            price_out_reg <= s2_price_reg;
            profit_reg    <= profit_next;
            date_out_reg  <= s2_date_reg;
            held_reg      <= holding_next;
        end
    end

    assign result_valid  = out_valid_reg;
    assign signal        = sig_reg;
    assign trade_price   = price_out_reg;
    assign profit        = signed'(profit_reg);
    assign date_echo     = date_out_reg;
    assign position_held = held_reg;

endmodule

// ----- rtl/smax_checker.sv -----
// Port-level checker for the crossover block, bound to the top level.
`timescale 1ns / 1ps
`include "sma_crossover_signal_defines.svh"
module smax_checker
    import smax_pkg::*;
(
    input logic                       clk,
    input logic                       rst_n,
    input logic                       result_valid,
    input logic                       result_ready,
    input logic [1:0]                 signal,
    input logic signed [PROFIT_W-1:0] profit,
    input logic                       position_held
);

    `SMAX_ASSERT_NOW(a_buy_holds, result_valid && (signal == SIG_BUY), position_held, "buy beat without position")
    `SMAX_ASSERT_NOW(a_sell_flat, result_valid && (signal == SIG_SELL), !position_held, "sell beat still holding")
    `SMAX_ASSERT_NOW(a_profit_zero, result_valid && (signal != SIG_SELL), profit == '0, "profit on non-sell beat")
    `SMAX_ASSERT_NXT(a_result_hold, result_valid && !result_ready, result_valid && $stable(signal) && $stable(profit), "stalled result beat changed")

endmodule

bind sma_crossover_signal smax_checker u_smax_checker (.*);

// ----- sim/sma_crossover_signal_tb.sv -----
// Testbench: checks the moving average crossover block against a trade predictor.
`timescale 1ns / 1ps
module sma_crossover_signal_tb;
    import smax_pkg::*;

    localparam int     RING_DEPTH     = MAX_PERIOD_DEFAULT;
    localparam int     PTR_W          = $clog2(RING_DEPTH);
    localparam int     PHASES         = 11;
    localparam int     PHASE_ITEMS    = 180;
    localparam int     LONG_HOLD      = 300;
    localparam int     WATCHDOG_LIMIT = 5000;
    localparam longint PRICE_MAX      = 64'h0000_0000_FFFF_FFFF;

    typedef struct {
        signal_t               sig;
        logic [PRICE_W-1:0]    trade;
        logic [PROFIT_W-1:0]   gain;
        logic [PRICE_W-1:0]    date;
        logic                  held;
    } trade_t;

    class trade_predictor;
        logic [PERIOD_W-1:0] short_len;
        logic [PERIOD_W-1:0] long_len;
        logic [PRICE_W-1:0]  prices [RING_DEPTH];
        logic [PTR_W-1:0]    head;
        int                  fill;
        logic                holding;
        logic [PRICE_W-1:0]  entry;
        trade_t              pending_trades [$];
        int                  mismatches;

        function new();
            short_len  = SHORT_PERIOD_RESET;
            long_len   = LONG_PERIOD_RESET;
            head       = '0;
            fill       = 0;
            holding    = 1'b0;
            entry      = '0;
            mismatches = 0;
        endfunction

        function void set_period(reg_index_t idx, logic [PERIOD_W-1:0] len);
            if (idx == REG_SHORT_PERIOD)
                short_len = len;
            else
                long_len = len;
        endfunction

        function int clamp_len(logic [PERIOD_W-1:0] len);
            if (len == 0)
                return 1;
            if (len > RING_DEPTH)
                return RING_DEPTH;
            return int'(len);
        endfunction

        // newest price sits just below head
        function longint unsigned window_total(int len);
            longint unsigned  acc;
            logic [PTR_W-1:0] idx;
            acc = 0;
            for (int k = 0; k < len; k++)
            begin
                idx = head - PTR_W'(k + 1);
                acc += prices[idx];
            end
            return acc;
        endfunction

        function void take_price(logic [PRICE_W-1:0] price, logic [PRICE_W-1:0] date);
            int              sl;
            int              ll;
            longint unsigned ssum;
            longint unsigned lsum;
            trade_t          t;
            sl = clamp_len(short_len);
            ll = clamp_len(long_len);
            prices[head] = price;
            head++;
            if (fill < RING_DEPTH)
                fill++;
            t.sig   = SIG_NONE;
            t.trade = price;
            t.gain  = '0;
            t.date  = date;
            if (fill >= sl && fill >= ll)
            begin
                ssum = window_total(sl);
                lsum = window_total(ll);
                if (ssum != 0 && lsum != 0)
                begin
                    if (!holding && ssum * ll > lsum * sl)
                    begin
                        t.sig   = SIG_BUY;
                        holding = 1'b1;
                        entry   = price;
                    end
                    else if (holding && ssum * ll < lsum * sl)
                    begin
                        t.sig   = SIG_SELL;
                        t.gain  = {1'b0, price} - {1'b0, entry};
                        holding = 1'b0;
                    end
                end
            end
            t.held = holding;
            pending_trades.insert(pending_trades.size(), t);
        endfunction

        function void compare(string what, logic [63:0] want, logic [63:0] got);
            if (want !== got)
            begin
                mismatches++;
                $display("%0t: %s mismatch: expected %0h, actual %0h", $time, what, want, got);
            end
        endfunction

        function void check_trade(logic [1:0] sig, logic [PRICE_W-1:0] trade,
                                  logic [PROFIT_W-1:0] gain, logic [PRICE_W-1:0] date,
                                  logic held);
            trade_t t;
            if (pending_trades.size() == 0)
            begin
                mismatches++;
                $display("%0t: result beat with nothing expected: expected none, actual %0h",
                         $time, trade);
                return;
            end
            t = pending_trades.pop_front();
            compare("signal", t.sig, sig);
            compare("trade_price", t.trade, trade);
            compare("profit", t.gain, gain);
            compare("date_echo", t.date, date);
            compare("position_held", t.held, held);
        endfunction
    endclass

    logic                       clk;
    logic                       rst_n;
    logic                       psel;
    logic                       penable;
    logic                       pwrite;
    logic [PADDR_W-1:0]         paddr;
    logic [PDATA_W-1:0]         pwdata;
    logic [PDATA_W-1:0]         prdata;
    logic                       pready;
    logic                       price_valid;
    logic                       price_ready;
    logic [PRICE_W-1:0]         close_price;
    logic [PRICE_W-1:0]         date_tag;
    logic                       result_valid;
    logic                       result_ready;
    logic [1:0]                 signal;
    logic [PRICE_W-1:0]         trade_price;
    logic signed [PROFIT_W-1:0] profit;
    logic [PRICE_W-1:0]         date_echo;
    logic                       position_held;

    trade_predictor pred;
    bit             calm;
    int             stall_requests;
    longint         walk;
    longint         slope;
    longint         amp;

    sma_crossover_signal u_top (.*);

    initial
    begin
        clk = 1'b0;
    end

    always #10 clk = ~clk;

    task automatic apb_write(reg_index_t idx, logic [PERIOD_W-1:0] len);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= PDATA_W'(len);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        pred.set_period(idx, len);
        // read back
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        pred.compare("period readback", PDATA_W'(len), prdata);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic program_periods(logic [PERIOD_W-1:0] s_len, logic [PERIOD_W-1:0] l_len);
        apb_write(REG_SHORT_PERIOD, s_len);
        apb_write(REG_LONG_PERIOD, l_len);
    endtask

    task automatic send_price(logic [PRICE_W-1:0] price, logic [PRICE_W-1:0] date);
        while (!calm && $urandom_range(0, 99) < 20)
        begin
            price_valid <= 1'b0;
            @(posedge clk);
        end
        price_valid <= 1'b1;
        close_price <= price;
        date_tag    <= date;
        @(posedge clk);
        while (!price_ready)
            @(posedge clk);
        pred.take_price(price, date);
    endtask

    // sender waits for every outstanding trade, then covers the pipeline latency
    task automatic drain();
        price_valid <= 1'b0;
        while (pred.pending_trades.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // trending walk with reversals, plus some raw and extreme prices
    task automatic next_price(output logic [PRICE_W-1:0] price);
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 5)
            price = $urandom;
        else if (roll < 7)
            price = '0;
        else if (roll < 9)
            price = '1;
        else
        begin
            if ($urandom_range(0, 15) == 0)
                slope = longint'($urandom_range(0, 32'(2 * amp))) - amp;
            walk += slope + longint'($urandom_range(0, 32'(amp / 2))) - amp / 4;
            if (walk < 0)
            begin
                walk  = 0;
                slope = -slope;
            end
            else if (walk > PRICE_MAX)
            begin
                walk  = PRICE_MAX;
                slope = -slope;
            end
            price = walk[PRICE_W-1:0];
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && result_valid && result_ready)
            pred.check_trade(signal, trade_price, profit, date_echo, position_held);
    end

    initial
    begin
        int hold_left;
        int stalls_served;
        hold_left     = 0;
        stalls_served = 0;
        result_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (stall_requests > stalls_served)
            begin
                stalls_served++;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                result_ready <= 1'b0;
            end
            else
                result_ready <= calm || ($urandom_range(0, 99) >= 20);
        end
    end

    initial
    begin
        int quiet;
        quiet = 0;
        forever
        begin
            @(posedge clk);
            if ((price_valid && price_ready) || (result_valid && result_ready) ||
                (psel && penable && pready))
                quiet = 0;
            else
                quiet++;
            if (quiet >= WATCHDOG_LIMIT)
            begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    initial
    begin
        logic [PRICE_W-1:0]  edge_prices [14];
        int                  short_set [9];
        int                  long_set [9];
        int                  scale_set [4];
        logic [PRICE_W-1:0]  price;
        logic [PERIOD_W-1:0] s_len;
        logic [PERIOD_W-1:0] l_len;

        edge_prices = '{32'h1, 32'hFFFF_FFFF, 32'h1, 32'h0, 32'h0, 32'h5, 32'h5, 32'h0,
                        32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h5555_5555,
                        32'hAAAA_AAAA, 32'h2};
        short_set   = '{5, 0, 127, 64, 1, 64, 3, 10, 2};
        long_set    = '{20, 127, 0, 64, 64, 1, 10, 3, 40};
        scale_set   = '{4, 12, 20, 30};

        pred           = new();
        calm           = 1'b0;
        stall_requests = 0;
        rst_n       <= 1'b0;
        psel        <= 1'b0;
        penable     <= 1'b0;
        pwrite      <= 1'b0;
        paddr       <= '0;
        pwdata      <= '0;
        price_valid <= 1'b0;
        close_price <= '0;
        date_tag    <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: filling, zero sums, equal averages, extreme prices and dates
        program_periods(7'd1, 7'd2);
        foreach (edge_prices[i])
            send_price(edge_prices[i], (i == 0) ? 32'h0 : (i == 1) ? 32'hFFFF_FFFF : $urandom);
        drain();

        for (int ph = 0; ph < PHASES; ph++)
        begin
            if (ph < 9)
            begin
                s_len = PERIOD_W'(short_set[ph]);
                l_len = PERIOD_W'(long_set[ph]);
            end
            else
            begin
                s_len = PERIOD_W'($urandom_range(0, 127));
                l_len = PERIOD_W'($urandom_range(0, 127));
            end
            program_periods(s_len, l_len);
            amp   = longint'(1) << scale_set[ph % 4];
            walk  = longint'($urandom);
            slope = amp;
            calm  = (ph == 3);
            if (ph == 5 || ph == 8)
                stall_requests++;
            repeat (PHASE_ITEMS)
            begin
                next_price(price);
                send_price(price, $urandom);
            end
            drain();
        end

        repeat (8) @(posedge clk);
        if (pred.mismatches == 0 && pred.pending_trades.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/smax_pkg.sv
rtl/smax_cfg.sv
rtl/smax_ring.sv
rtl/sma_crossover_signal.sv
rtl/smax_checker.sv
sim/sma_crossover_signal_tb.sv
